// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the trial division prime test
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_AT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ===== rtl/tdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpt_pkg
// shared types and constants of the trial division prime test
// ----------------------------------------------------------------------------
package tdpt_pkg;

   localparam int NUM_WIDTH_DEF = 31;
   localparam int FIRST_DIVISOR = 3;
   localparam int DIVISOR_STEP  = 2;

   typedef struct packed {
      logic load;
      logic div_init;
      logic div_step;
      logic next_divisor;
   } tdpt_cmd_type;

   typedef struct packed {
      logic below_two;
      logic below_four;
      logic even;
      logic div_last;
      logic bound_ok;
      logic rem_zero;
   } tdpt_status_type;

endpackage

// ===== rtl/tdpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tdpt_datapath
// candidate and divisor registers with a bit-serial restoring divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpt_datapath #(
   parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [NUM_WIDTH-1:0]   req_candidate,
   input  tdpt_pkg::tdpt_cmd_type cmd,
   output tdpt_pkg::tdpt_status_type status
);
   import tdpt_pkg::*;

   localparam int CNT_W = $clog2(NUM_WIDTH);

   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [NUM_WIDTH-1:0] div_ff, div_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [NUM_WIDTH+1:0] trial;

   assign trial = {1'b0, rem_ff, quo_ff[NUM_WIDTH-1]} - {2'b00, div_ff};

   always_comb begin
      num_in = num_ff;
      div_in = div_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      priority if (cmd.load) begin
         num_in = req_candidate;
         div_in = NUM_WIDTH'(FIRST_DIVISOR);
      end else if (cmd.next_divisor || cmd.div_init) begin
         if (cmd.next_divisor) begin
            div_in = div_ff + NUM_WIDTH'(DIVISOR_STEP);
         end
         rem_in = '0;
         quo_in = num_ff;
         cnt_in = CNT_W'(NUM_WIDTH - 1);
      end else if (cmd.div_step) begin
         if (!trial[NUM_WIDTH+1]) begin
            rem_in = trial[NUM_WIDTH-1:0];
            quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[NUM_WIDTH-2:0], quo_ff[NUM_WIDTH-1]};
            quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      status.below_two  = (num_ff[NUM_WIDTH-1:1] == '0);
      status.below_four = (num_ff[NUM_WIDTH-1:2] == '0);
      status.even       = !num_ff[0];
      status.div_last   = (cnt_ff == '0);
      status.bound_ok   = (div_ff <= quo_ff);
      status.rem_zero   = (rem_ff == '0);
   end

   `ASSERT_AT(a_rem_below_div, clock, reset, (cmd.div_step |=> rem_ff < div_ff))
   `ASSERT_AT(a_div_odd, clock, reset, (cmd.next_divisor |=> div_ff[0]))

endmodule

// ===== rtl/tdpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdpt_ctrl
// sequencer for classification, division runs and result strobe
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpt_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic                      rsp_is_prime,
   output tdpt_pkg::tdpt_cmd_type    cmd,
   input  tdpt_pkg::tdpt_status_type status
);
   import tdpt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIVIDE,
      ST_CHECK
   } state_type;

   state_type state_ff;
   logic      valid_ff;
   logic      prime_ff;

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = valid_ff;
   assign rsp_is_prime = prime_ff;

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_CLASSIFY: begin
            cmd.div_init = !(status.below_two || status.below_four || status.even);
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_CHECK: begin
            cmd.next_divisor = status.bound_ok && !status.rem_zero;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         prime_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               priority if (status.below_two) begin
                  valid_ff <= 1'b1;
                  prime_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else if (status.below_four) begin
                  valid_ff <= 1'b1;
                  prime_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (status.even) begin
                  valid_ff <= 1'b1;
                  prime_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            ST_DIVIDE: begin
               if (status.div_last) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               priority if (!status.bound_ok) begin
                  valid_ff <= 1'b1;
                  prime_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (status.rem_zero) begin
                  valid_ff <= 1'b1;
                  prime_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIVIDE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEVER(a_no_strobe_while_busy, clock, reset, (busy && rsp_valid))
   `ASSERT_AT(a_start_takes, clock, reset, (start && !busy |=> busy))

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// ----------------------------------------------------------------------------
// trial_division_prime_test
// answers whether an unsigned candidate number is prime by trial division
// ----------------------------------------------------------------------------
// usage:
//   a request is taken at a rising edge with start high and busy low; the
//   candidate is on req_candidate. busy stays high while the test runs.
//   the answer is on rsp_is_prime, marked by rsp_valid high for exactly one
//   cycle, in the same cycle that busy falls; the receiver cannot stall.
// sequence:
//   values below four and even values are answered from the classify state.
//   for odd values, k odd divisors are tried from 3 (k is at most about
//   sqrt(candidate) / 2). each divisor costs one bit-serial restoring
//   division of NUM_WIDTH steps, which gives both the remainder and the
//   quotient for the bound check, and then a visit to the check state.
// throughput:
//   one request at a time; a new request may start in the strobe cycle.
// reset:
//   synchronous reset returns the block to idle and drops any test in flight.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
   parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [NUM_WIDTH-1:0] req_candidate,
   output logic                 rsp_valid,
   output logic                 rsp_is_prime
);
   import tdpt_pkg::*;

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdpt_datapath #(
      .NUM_WIDTH (NUM_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_candidate (req_candidate),
      .cmd           (cmd),
      .status        (status)
   );

endmodule
